// ===== rtl/tscc_pkg.sv =====
package tscc_pkg;

    localparam int unsigned PAD_BYTES = 9;
    localparam int unsigned CNT_W     = 4;

    localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(PAD_BYTES - 1);
    localparam logic [CNT_W-1:0] IDX_TLO    = CNT_W'(0);
    localparam logic [CNT_W-1:0] IDX_THI    = CNT_W'(1);
    localparam logic [CNT_W-1:0] IDX_CONF   = CNT_W'(4);
    localparam logic [CNT_W-1:0] IDX_REMAIN = CNT_W'(6);

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [7:0] FAM_9BIT  = 8'h10;
    localparam logic [7:0] FAM_12B_A = 8'h28;
    localparam logic [7:0] FAM_12B_B = 8'h22;

    localparam logic [1:0] RES_9  = 2'b00;
    localparam logic [1:0] RES_10 = 2'b01;
    localparam logic [1:0] RES_11 = 2'b10;

    localparam logic [15:0] EXT_OFFSET   = 16'd12;
    localparam logic [13:0] FRAC_SCALE   = 14'd640;
    localparam logic [13:0] FRAC_HALF    = 14'd512;
    localparam logic [15:0] TEMP_MAX_MAG = 16'd1250;
    localparam logic [15:0] TEMP_MIN_MAG = 16'd550;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic        crc_ok;
        logic [7:0]  fam;
        logic [15:0] raw;
        logic [1:0]  res;
        logic [7:0]  remain;
    } t_job;

    function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = c_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/tscc_front.sv =====
module tscc_front import tscc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_vld,
    output logic       o_byte_rdy,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_fam,
    input  logic       i_q_full,
    output logic       o_job_vld,
    output t_job       o_job
);

    logic [7:0]       r_crc;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_tlo;
    logic [7:0]       r_thi;
    logic [7:0]       r_conf;
    logic [7:0]       r_remain;

    logic [7:0] n_crc;
    logic [7:0] n_tlo;
    logic [7:0] n_thi;
    logic [7:0] n_conf;
    logic [7:0] n_remain;
    logic       acc;
    logic       last;

    assign o_byte_rdy = !i_q_full;
    assign acc        = i_byte_vld && !i_q_full;
    assign last       = (r_cnt == LAST_IDX);
    assign n_crc      = crc8_byte(r_crc, i_byte);

    always_comb begin
        n_tlo    = r_tlo;
        n_thi    = r_thi;
        n_conf   = r_conf;
        n_remain = r_remain;
        unique case (r_cnt)
            IDX_TLO:    n_tlo    = i_byte;
            IDX_THI:    n_thi    = i_byte;
            IDX_CONF:   n_conf   = i_byte;
            IDX_REMAIN: n_remain = i_byte;
            default: ;
        endcase
    end

    assign o_job_vld = acc && last;
    assign o_job     = {(n_crc == 8'h00), i_fam, n_thi, n_tlo, n_conf[6:5], n_remain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= '0;
            r_cnt    <= '0;
            r_tlo    <= '0;
            r_thi    <= '0;
            r_conf   <= '0;
            r_remain <= '0;
        end else if (acc) begin
            r_crc    <= last ? '0 : n_crc;
            r_cnt    <= last ? '0 : CNT_W'(r_cnt + 1'b1);
            r_tlo    <= n_tlo;
            r_thi    <= n_thi;
            r_conf   <= n_conf;
            r_remain <= n_remain;
        end
    end

endmodule

// ===== rtl/tscc_queue.sv =====
module tscc_queue import tscc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_vld,
    output t_job o_job,
    input  logic i_pop
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : Q_PTR_W'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : Q_PTR_W'(r_rp + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= (Q_PTR_W+1)'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= (Q_PTR_W+1)'(r_cnt - 1'b1);
            end
        end
    end

endmodule

// ===== rtl/tscc_back.sv =====
module tscc_back import tscc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_vld,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_vld,
    input  logic               i_rdy,
    output t_status            o_status,
    output logic signed [11:0] o_temp
);

    logic        r_s1_vld;
    logic        r_s1_ok;
    logic        r_s1_neg;
    logic [15:0] r_s1_mag;

    logic               r_out_vld;
    t_status            r_out_status;
    logic signed [11:0] r_out_temp;

    logic        out_adv;
    logic        s1_adv;
    logic [15:0] ext_raw;
    logic [15:0] raw_sel;
    logic        neg;
    logic [15:0] mag_abs;
    logic [15:0] mag;
    logic        is_12b;

    logic [15:0] int10;
    logic [13:0] frac_num;
    logic [15:0] sum;
    logic        in_range;
    t_status     n_status;
    logic [11:0] n_temp;

    assign out_adv = !r_out_vld || i_rdy;
    assign s1_adv  = !r_s1_vld || out_adv;
    assign o_pop   = i_job_vld && s1_adv;

    assign ext_raw = 16'({i_job.raw[12:1], 4'b0000} + EXT_OFFSET - {8'h00, i_job.remain});
    assign raw_sel = (i_job.fam == FAM_9BIT) ? ext_raw : i_job.raw;
    assign neg     = raw_sel[15];
    assign mag_abs = neg ? 16'(16'h0000 - raw_sel) : raw_sel;
    assign is_12b  = (i_job.fam == FAM_12B_A) || (i_job.fam == FAM_12B_B);

    always_comb begin
        mag = mag_abs;
        if (is_12b) begin
            unique case (i_job.res)
                RES_9:   mag = {mag_abs[15:3], 3'b000};
                RES_10:  mag = {mag_abs[15:2], 2'b00};
                RES_11:  mag = {mag_abs[15:1], 1'b0};
                default: mag = mag_abs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= i_job_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_ok  <= i_job.crc_ok;
            r_s1_neg <= neg;
            r_s1_mag <= mag;
        end
    end

    assign int10    = {1'b0, r_s1_mag[15:4], 3'b000} + {3'b000, r_s1_mag[15:4], 1'b0};
    assign frac_num = 14'(r_s1_mag[3:0] * FRAC_SCALE) + (r_s1_neg ? 14'd0 : FRAC_HALF);
    assign sum      = int10 + {12'h000, frac_num[13:10]};
    assign in_range = r_s1_neg ? (sum <= TEMP_MIN_MAG) : (sum <= TEMP_MAX_MAG);

    always_comb begin
        n_status = ST_OK;
        n_temp   = '0;
        if (!r_s1_ok) begin
            n_status = ST_CRC;
        end else if (!in_range) begin
            n_status = ST_RANGE;
        end else begin
            n_temp = r_s1_neg ? 12'(12'h000 - sum[11:0]) : sum[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_vld) begin
            r_out_status <= n_status;
            r_out_temp   <= $signed(n_temp);
        end
    end

    assign o_vld    = r_out_vld;
    assign o_status = r_out_status;
    assign o_temp   = r_out_temp;

endmodule

// ===== rtl/temp_scratchpad_check_convert.sv =====
// The last accepted scratchpad byte pushes a job into the two-entry job queue, which decouples
// byte intake from the two-stage conversion: stage-1 register, then output register; output
// back-pressure can hold a job in either. Intake takes one byte per cycle while the queue is not
// full. Reset (synchronous, active low) clears the CRC, byte counter, stored bytes, queue and
// pipeline valid flags.
module temp_scratchpad_check_convert import tscc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scratch_byte
    input  logic [7:0]  s_axis_tuser,   // [7:0] family_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] temp_deci, [15:12] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic               q_full;
    logic               q_push;
    t_job               q_in;
    logic               q_vld;
    t_job               q_out;
    logic               q_pop;
    t_status            out_status;
    logic signed [11:0] out_temp;

    tscc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (s_axis_tvalid),
        .o_byte_rdy (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_fam      (s_axis_tuser),
        .i_q_full   (q_full),
        .o_job_vld  (q_push),
        .o_job      (q_in)
    );

    tscc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_job   (q_out),
        .i_pop   (q_pop)
    );

    tscc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (q_vld),
        .i_job     (q_out),
        .o_pop     (q_pop),
        .o_vld     (m_axis_tvalid),
        .i_rdy     (m_axis_tready),
        .o_status  (out_status),
        .o_temp    (out_temp)
    );

    assign m_axis_tdata = {4'h0, out_temp};
    assign m_axis_tuser = out_status;

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (s_axis_tvalid && s_axis_tready))
        else $error("job pushed without an accepted transaction");

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == 16'h0000))
        else $error("non-zero temperature with error status");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_OK)) |->
            (($signed(m_axis_tdata[11:0]) >= -12'sd550) &&
             ($signed(m_axis_tdata[11:0]) <= 12'sd1250)))
        else $error("temperature out of range with ok status");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_vld)
        else $error("queue popped while empty");

endmodule

// ===== tb/tb_temp_scratchpad_check_convert.sv =====
`timescale 1ns / 1ps

module tb_temp_scratchpad_check_convert;
    import tscc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RAND_FRAMES = 100;

    class temp_frame_scoreboard;
        typedef struct {
            t_status    status;
            logic [11:0] temp;
        } reading_t;

        reading_t         readings_q[$];
        logic [7:0]       crc;
        logic [CNT_W-1:0] idx;
        logic [7:0]       lo, hi, conf, remain;
        int               errors, n_frames, n_ok, n_crc, n_range;

        function new();
            crc = '0;
            idx = '0;
            lo = '0;
            hi = '0;
            conf = '0;
            remain = '0;
            errors = 0;
            n_frames = 0;
            n_ok = 0;
            n_crc = 0;
            n_range = 0;
        endfunction

        static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            for (int k = 0; k < 8; k++) begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function int to_deci(logic [7:0] fam);
            logic [15:0] raw, mag;
            bit          neg;
            int unsigned frac;
            int          t;
            raw = {hi, lo};
            if (fam == FAM_9BIT) begin
                raw = {raw[15:1], 1'b0} << 3;
                raw = raw + EXT_OFFSET - {8'h00, remain};
            end
            neg = raw[15];
            mag = neg ? 16'(-raw) : raw;
            if (fam == FAM_12B_A || fam == FAM_12B_B) begin
                case (conf[6:5])
                    RES_9: mag[2:0] = '0;
                    RES_10: mag[1:0] = '0;
                    RES_11: mag[0] = 1'b0;
                    default: ;
                endcase
            end
            frac = int'(mag[3:0]) * int'(FRAC_SCALE) + (neg ? 0 : int'(FRAC_HALF));
            frac = frac / 1024;
            t = int'(mag[15:4]) * 10 + int'(frac);
            return neg ? -t : t;
        endfunction

        function void note_byte(logic [7:0] b, logic [7:0] fam);
            reading_t r;
            int       t;
            crc = crc_step(crc, b);
            case (idx)
                IDX_TLO: lo = b;
                IDX_THI: hi = b;
                IDX_CONF: conf = b;
                IDX_REMAIN: remain = b;
                default: ;
            endcase
            if (idx != LAST_IDX) begin
                idx = idx + 1'b1;
                return;
            end
            r.temp = '0;
            if (crc != 8'h00) begin
                r.status = ST_CRC;
                n_crc++;
            end else begin
                t = to_deci(fam);
                if (t < -int'(TEMP_MIN_MAG) || t > int'(TEMP_MAX_MAG)) begin
                    r.status = ST_RANGE;
                    n_range++;
                end else begin
                    r.status = ST_OK;
                    r.temp = 12'(t);
                    n_ok++;
                end
            end
            readings_q.push_back(r);
            n_frames++;
            crc = '0;
            idx = '0;
        endfunction

        task report(string field, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d", field, got, want);
            errors++;
        endtask

        task check_reading(logic [1:0] st, logic [15:0] data);
            reading_t want;
            if (readings_q.size() == 0) begin
                report("unexpected result, status", int'(st), -1);
                return;
            end
            want = readings_q.pop_front();
            if (st !== want.status) report("status", int'(st), int'(want.status));
            if (data[11:0] !== want.temp)
                report("temp_deci", int'($signed(data[11:0])), int'($signed(want.temp)));
            if (data[15:12] !== 4'h0) report("tdata upper bits", int'(data[15:12]), 0);
        endtask

        function int pending();
            return readings_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] scratch_byte
    logic [7:0]  s_axis_tuser;   // [7:0] family_code
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [11:0] temp_deci, [15:12] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status

    temp_frame_scoreboard sb = new();
    bit          tx_burst;
    bit          rx_burst;
    int unsigned cycles = 0;

    temp_scratchpad_check_convert u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic [7:0] fam);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= fam;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, fam);
    endtask

    task automatic send_frame(logic [15:0] raw, logic [7:0] fam, logic [7:0] conf,
                              logic [7:0] remain, bit corrupt);
        logic [7:0] pad [PAD_BYTES];
        logic [7:0] crc;
        crc = '0;
        for (int i = 0; i < PAD_BYTES; i++) pad[i] = 8'($urandom_range(0, 255));
        pad[IDX_TLO] = raw[7:0];
        pad[IDX_THI] = raw[15:8];
        if (IDX_CONF < LAST_IDX) pad[IDX_CONF] = conf;
        if (IDX_REMAIN < LAST_IDX) pad[IDX_REMAIN] = remain;
        for (int i = 0; i < PAD_BYTES - 1; i++) crc = temp_frame_scoreboard::crc_step(crc, pad[i]);
        pad[PAD_BYTES-1] = crc;
        if (corrupt)
            pad[$urandom_range(0, PAD_BYTES - 1)][$urandom_range(0, 7)] ^= 1'b1;
        for (int i = 0; i < PAD_BYTES; i++)
            send_byte(pad[i], (i == PAD_BYTES - 1) ? fam : 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_family();
        case ($urandom_range(0, 3))
            0: return FAM_9BIT;
            1: return FAM_12B_A;
            2: return FAM_12B_B;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [15:0] raw;
        logic [7:0]  fam;
        logic [7:0]  remain;
        int          sel;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        tx_burst = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // magnitude 0x8000, top of range with unknown family, bottom of range, bad CRC
        send_frame(16'h8000, FAM_12B_A, 8'h7F, 8'h00, 1'b0);
        send_frame(16'h07D0, 8'h5A, 8'h00, 8'h00, 1'b0);
        send_frame(16'hFC90, FAM_12B_B, 8'h1F, 8'h0C, 1'b0);
        send_frame(16'h0032, FAM_9BIT, 8'h00, 8'hFF, 1'b1);

        for (int f = 0; f < RAND_FRAMES; f++) begin
            tx_burst = ($urandom_range(0, 4) == 0);
            if (f == RAND_FRAMES / 2) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            sel = $urandom_range(0, 99);
            remain = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 16));
            if (sel < 35) begin
                raw = 16'($urandom_range(0, 2880) - 880);
                fam = $urandom_range(0, 1) ? FAM_12B_A : FAM_12B_B;
            end else if (sel < 60) begin
                raw = 16'($urandom_range(0, 360) - 110);
                fam = FAM_9BIT;
            end else if (sel < 75) begin
                raw = 16'($urandom_range(0, 16'hFFFF));
                fam = pick_family();
            end else if (sel < 92) begin
                case ($urandom_range(0, 7))
                    0: raw = 16'h8000;
                    1: raw = 16'h7FFF;
                    2: raw = 16'hFC90;
                    3: raw = 16'hFC8F;
                    4: raw = 16'h07D0;
                    5: raw = 16'h07D1;
                    6: raw = 16'h0000;
                    default: raw = 16'hFFFF;
                endcase
                fam = pick_family();
            end else begin
                for (int i = 0; i < PAD_BYTES; i++)
                    send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                continue;
            end
            send_frame(raw, fam, 8'($urandom_range(0, 255)), remain, $urandom_range(0, 9) == 0);
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d scratchpad frames across 9-bit, 12-bit and unknown families",
                 sb.n_frames);
        $display("Outcomes: %0d converted, %0d CRC failures, %0d out of range",
                 sb.n_ok, sb.n_crc, sb.n_range);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        int unsigned stall;
        rx_burst = 1'b0;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_reading(m_axis_tuser, m_axis_tdata);
        end
    end

endmodule

// ===== temp_scratchpad_check_convert.f =====
rtl/tscc_pkg.sv
rtl/tscc_front.sv
rtl/tscc_queue.sv
rtl/tscc_back.sv
rtl/temp_scratchpad_check_convert.sv
tb/tb_temp_scratchpad_check_convert.sv
